// ===== hdl/hsad_pkg.sv =====
// ----------------------------------------------------------------------------
// Hall sensor angle decoder package
// Shared types, codes and the six-step lookup tables of the Hall decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hsad_pkg;

    // Fraction bits of the mechanical angle, in degrees.
    localparam int ANGLE_FRAC_BITS = 10;

    // Reset value of the mechanical step: 60 degrees, saturated to 16 bits.
    localparam longint MECH_STEP_FULL  = 60 * (64'sd1 <<< ANGLE_FRAC_BITS);
    localparam logic [15:0] MECH_STEP_RESET =
        (MECH_STEP_FULL > 65535) ? 16'hFFFF : MECH_STEP_FULL[15:0];

    // Configuration register indexes.
    localparam logic [1:0] CFG_SWAP_BC      = 2'd0;
    localparam logic [1:0] CFG_ANGLE_OFFSET = 2'd1;
    localparam logic [1:0] CFG_MECH_STEP    = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_INVALID = 2'd1,
        ST_ILLEGAL = 2'd2
    } status_t;

    // Step direction codes (two-bit signed).
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_CW   = 2'sb01;
    localparam logic signed [1:0] DIR_CCW  = 2'sb11;

    // Configuration register file contents.
    typedef struct packed {
        logic               swap_bc;
        logic signed [15:0] angle_offset;
        logic        [15:0] mech_step;
    } cfg_t;

    // Decoder state carried from one capture to the next.
    typedef struct packed {
        logic        [2:0]  prev_pattern;
        logic        [2:0]  curr_pattern;
        logic               first_capture;
        logic signed [17:0] elec_angle;
        logic        [8:0]  elec_degrees;
        logic        [2:0]  sector;
        logic signed [31:0] mech_angle;
    } state_t;

    // One result word.
    typedef struct packed {
        status_t            status;
        logic        [2:0]  hall_state;
        logic signed [17:0] elec_angle;
        logic        [8:0]  elec_degrees;
        logic        [2:0]  elec_sector;
        logic signed [31:0] mech_angle;
        logic signed [1:0]  step_dir;
    } result_t;

    // Pattern that follows p when the rotor turns clockwise.
    function automatic logic [2:0] next_cw(input logic [2:0] p);
        logic [2:0] r;
        case (p)
            3'd1:    r = 3'd5;
            3'd2:    r = 3'd3;
            3'd3:    r = 3'd1;
            3'd4:    r = 3'd6;
            3'd5:    r = 3'd4;
            3'd6:    r = 3'd2;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Pattern that follows p when the rotor turns counter-clockwise.
    function automatic logic [2:0] next_ccw(input logic [2:0] p);
        logic [2:0] r;
        case (p)
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd6;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd5;
            3'd5:    r = 3'd1;
            3'd6:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Sector number of a pattern.
    function automatic logic [2:0] sector_of(input logic [2:0] p);
        logic [2:0] r;
        case (p)
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd3;
            3'd5:    r = 3'd5;
            3'd6:    r = 3'd1;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // Sector centre angle, 65536 units per turn.
    function automatic logic [16:0] angle_of(input logic [2:0] p);
        logic [16:0] r;
        case (p)
            3'd1:    r = 17'd43690;
            3'd2:    r = 17'd21845;
            3'd3:    r = 17'd32768;
            3'd5:    r = 17'd54613;
            3'd6:    r = 17'd10922;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // Sector centre angle in whole degrees.
    function automatic logic [8:0] degrees_of(input logic [2:0] p);
        logic [8:0] r;
        case (p)
            3'd1:    r = 9'd240;
            3'd2:    r = 9'd120;
            3'd3:    r = 9'd180;
            3'd5:    r = 9'd300;
            3'd6:    r = 9'd60;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/hall_sensor_angle_decoder.sv =====
// ----------------------------------------------------------------------------
// Hall sensor angle decoder
// Six-step BLDC Hall decoder: electrical sector and angle, mechanical angle.
// ----------------------------------------------------------------------------
// The decoder takes one Hall capture per word and returns one result word for
// each. It accepts a word every clock cycle unless a held result stalls the
// input register; a result word is offered once the decode step that updates
// the state has moved its capture from the input register into the result
// register. Both registers pass words on while the far side stalls only as far
// as space allows, so a held result does not block the next capture from
// entering the input register. Configuration writes take effect on the next
// edge; the user must make them while no capture is in flight, which the
// block itself does not enforce.
`default_nettype none

module hall_sensor_angle_decoder
    import hsad_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // Capture input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [2:0] hall_bits, [7:3] zero
    // Result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [2:0] hall_state, [20:3] elec_angle,
                                        // [29:21] elec_degrees, [32:30] elec_sector,
                                        // [64:33] mech_angle, [66:65] step_dir,
                                        // [71:67] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    cfg_t    cfg;
    state_t  state_reg;
    state_t  state_next;
    state_t  dec_state;
    result_t dec_result;
    result_t res_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic [2:0] in_bits_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    s_fire;
    logic    dec_ready;
    logic    dec_fire;

    hsad_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hsad_decode u_decode (
        .cfg        (cfg),
        .state      (state_reg),
        .hall_bits  (in_bits_reg),
        .state_next (dec_state),
        .result     (dec_result)
    );

    // Handshake between the input register, decode step and result register.
    assign dec_ready = !out_valid_reg || m_tready;
    assign dec_fire  = in_valid_reg && dec_ready;
    assign s_tready  = !in_valid_reg || dec_ready;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (dec_fire) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (dec_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        state_next = dec_fire ? dec_state : state_reg;
    end

    // Control and decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.prev_pattern  <= 3'd0;
            state_reg.curr_pattern  <= 3'd0;
            state_reg.first_capture <= 1'b1;
            state_reg.elec_angle    <= 18'sd0;
            state_reg.elec_degrees  <= 9'd0;
            state_reg.sector        <= 3'd0;
            state_reg.mech_angle    <= 32'sd0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_bits_reg <= s_tdata[2:0];
        end
        if (dec_fire) begin
            res_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {5'd0, res_reg.step_dir, res_reg.mech_angle, res_reg.elec_sector,
                       res_reg.elec_degrees, res_reg.elec_angle, res_reg.hall_state};

    // An invalid pattern leaves the decoder state untouched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        dec_fire && dec_result.status == ST_INVALID |=> $stable(state_reg))
        else $error("state changed on an invalid Hall pattern");

    // Once primed, the stored pattern is always a legal Hall code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.first_capture |-> state_reg.curr_pattern != 3'd0
                                  && state_reg.curr_pattern != 3'd7)
        else $error("stored Hall pattern is 0 or 7");

    // A step direction is only reported with a successful update.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_reg.step_dir == DIR_NONE || res_reg.status == ST_UPDATED)
        else $error("step direction reported without an update");

    // With the result register empty, the input is always ready for a new capture.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the result register is empty");

endmodule

`default_nettype wire

// ===== hdl/hsad_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Hall decoder configuration registers
// Write-only register file for the B/C swap, angle offset and mechanical step.
// ----------------------------------------------------------------------------
`default_nettype none

module hsad_cfg_regs
    import hsad_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; an index beyond the list changes nothing.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_SWAP_BC:      cfg_next.swap_bc      = cfg_wdata[0];
                CFG_ANGLE_OFFSET: cfg_next.angle_offset = $signed(cfg_wdata);
                CFG_MECH_STEP:    cfg_next.mech_step    = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.swap_bc      <= 1'b0;
            cfg_reg.angle_offset <= 16'sd0;
            cfg_reg.mech_step    <= MECH_STEP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/hsad_decode.sv =====
// ----------------------------------------------------------------------------
// Hall decoder step logic
// Pattern check, transition check, table lookup and saturating angle update.
// ----------------------------------------------------------------------------
`default_nettype none

module hsad_decode
    import hsad_pkg::*;
(
    input  wire cfg_t        cfg,
    input  wire state_t      state,
    input  wire logic [2:0]  hall_bits,
    output state_t           state_next,
    output result_t          result
);

    logic [2:0]         pat;
    logic               pat_bad;
    logic [2:0]         prev_new;
    logic signed [1:0]  dir;
    status_t            status;
    logic signed [33:0] delta;
    logic signed [33:0] mech_sum;
    logic signed [31:0] mech_sat;

    always_comb begin
        // Optional swap of bits B and C.
        pat     = cfg.swap_bc ? {hall_bits[1], hall_bits[2], hall_bits[0]} : hall_bits;
        pat_bad = (pat == 3'd0) || (pat == 3'd7);

        // The first valid capture primes both patterns.
        prev_new = state.first_capture ? pat : state.curr_pattern;

        // Classify the transition.
        dir    = DIR_NONE;
        status = ST_UPDATED;
        if (pat_bad) begin
            status = ST_INVALID;
        end else if (pat == prev_new) begin
            dir = DIR_NONE;
        end else if (pat == next_cw(prev_new)) begin
            dir = DIR_CW;
        end else if (pat == next_ccw(prev_new)) begin
            dir = DIR_CCW;
        end else begin
            status = ST_ILLEGAL;
        end

        // Mechanical angle step with saturation at the 32-bit limits.
        case (dir)
            DIR_CW:  delta = $signed({18'd0, cfg.mech_step});
            DIR_CCW: delta = -$signed({18'd0, cfg.mech_step});
            default: delta = 34'sd0;
        endcase
        mech_sum = $signed({{2{state.mech_angle[31]}}, state.mech_angle}) + delta;
        if (mech_sum[33:31] == 3'b000 || mech_sum[33:31] == 3'b111) begin
            mech_sat = mech_sum[31:0];
        end else if (mech_sum[33]) begin
            mech_sat = 32'sh8000_0000;
        end else begin
            mech_sat = 32'sh7FFF_FFFF;
        end

        // Next state: patterns move on any valid capture, angles only on success.
        state_next = state;
        if (!pat_bad) begin
            state_next.first_capture = 1'b0;
            state_next.prev_pattern  = prev_new;
            state_next.curr_pattern  = pat;
        end
        if (status == ST_UPDATED) begin
            state_next.elec_angle   = $signed({{2{cfg.angle_offset[15]}}, cfg.angle_offset})
                                    + $signed({1'b0, angle_of(pat)});
            state_next.elec_degrees = degrees_of(pat);
            state_next.sector       = sector_of(pat);
            state_next.mech_angle   = mech_sat;
        end

        // Result reflects the state after this capture.
        result.status       = status;
        result.hall_state   = state_next.curr_pattern;
        result.elec_angle   = state_next.elec_angle;
        result.elec_degrees = state_next.elec_degrees;
        result.elec_sector  = state_next.sector;
        result.mech_angle   = state_next.mech_angle;
        result.step_dir     = (status == ST_UPDATED) ? dir : DIR_NONE;
    end

endmodule

`default_nettype wire

// ===== verif/hall_decode_checker.sv =====
// ----------------------------------------------------------------------------
// Hall decoder result checker
// Watches the configuration port and both stream channels of the Hall sensor
// angle decoder. It predicts the result word of every accepted capture,
// compares each accepted result word against the oldest prediction, and
// reports the number of mismatches and predictions still waiting.
// ----------------------------------------------------------------------------
module hall_decode_checker
    import hsad_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [2:0] hall_bits, [7:3] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,    // [2:0] hall_state, [20:3] elec_angle,
                                    // [29:21] elec_degrees, [32:30] elec_sector,
                                    // [64:33] mech_angle, [66:65] step_dir,
                                    // [71:67] zero
    input  logic [1:0]  m_tuser,    // [1:0] status
    output int          fail_count,
    output int          outstanding
);

    localparam longint MECH_MAX = 64'sd2147483647;
    localparam longint MECH_MIN = -64'sd2147483648;

    // Shadow copy of the configuration registers.
    logic               cfg_swap;
    logic signed [15:0] cfg_offset;
    logic        [15:0] cfg_step;

    // Shadow copy of the decoder state.
    logic        [2:0]  prev_pat;
    logic        [2:0]  cur_pat;
    logic               fresh;
    logic signed [17:0] angle_hold;
    logic        [8:0]  deg_hold;
    logic        [2:0]  sec_hold;
    logic signed [31:0] mech_hold;

    // Predicted result words, oldest first.
    result_t angle_reports[$];
    int      errors = 0;

    assign fail_count = errors;

    // Sector of a decoded Hall pattern; the sectors run clockwise.
    function automatic logic [2:0] sector_for(input logic [2:0] pat);
        logic [2:0] s;
        case (pat)
            3'd4:    s = 3'd0;
            3'd6:    s = 3'd1;
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd3;
            3'd1:    s = 3'd4;
            3'd5:    s = 3'd5;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // Advance the shadow state by one capture and queue the result word.
    task automatic decode_capture(input logic [2:0] raw);
        logic [2:0] pat;
        logic [2:0] sec;
        int         diff;
        longint     delta;
        longint     sum;
        result_t    r;
        pat = cfg_swap ? {raw[1], raw[2], raw[0]} : raw;
        r = '0;
        r.status = ST_UPDATED;
        r.step_dir = DIR_NONE;
        delta = 0;
        if (pat == 3'd0 || pat == 3'd7) begin
            r.status = ST_INVALID;
        end else begin
            // The first valid capture primes both patterns.
            if (fresh) begin
                fresh = 1'b0;
                prev_pat = pat;
            end else begin
                prev_pat = cur_pat;
            end
            cur_pat = pat;
            diff = (int'(sector_for(cur_pat)) - int'(sector_for(prev_pat)) + 6) % 6;
            case (diff)
                0: r.step_dir = DIR_NONE;
                1: begin
                    r.step_dir = DIR_CW;
                    delta = longint'(cfg_step);
                end
                5: begin
                    r.step_dir = DIR_CCW;
                    delta = -longint'(cfg_step);
                end
                default: r.status = ST_ILLEGAL;
            endcase
            // An illegal jump keeps the new patterns but not the angles.
            if (r.status == ST_UPDATED) begin
                sec = sector_for(cur_pat);
                angle_hold = 18'(int'(cfg_offset) + int'(sec) * 65536 / 6);
                deg_hold = 9'(int'(sec) * 60);
                sec_hold = sec;
                sum = longint'(mech_hold) + delta;
                if (sum > MECH_MAX) begin
                    mech_hold = 32'h7FFF_FFFF;
                end else if (sum < MECH_MIN) begin
                    mech_hold = 32'h8000_0000;
                end else begin
                    mech_hold = sum[31:0];
                end
            end
        end
        r.hall_state = cur_pat;
        r.elec_angle = angle_hold;
        r.elec_degrees = deg_hold;
        r.elec_sector = sec_hold;
        r.mech_angle = mech_hold;
        angle_reports.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
        end
    endtask

    // Compare one result word against the oldest prediction.
    task automatic match_report();
        result_t want;
        if (angle_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, got tdata 'h%0h tuser 'h%0h",
                     $time, m_tdata, m_tuser);
        end else begin
            want = angle_reports.pop_front();
            check_field("status", want.status, m_tuser);
            check_field("hall_state", want.hall_state, m_tdata[2:0]);
            check_field("elec_angle", $unsigned(want.elec_angle), m_tdata[20:3]);
            check_field("elec_degrees", want.elec_degrees, m_tdata[29:21]);
            check_field("elec_sector", want.elec_sector, m_tdata[32:30]);
            check_field("mech_angle", want.mech_angle, m_tdata[64:33]);
            check_field("step_dir", $unsigned(want.step_dir), m_tdata[66:65]);
            check_field("tdata padding", 32'd0, m_tdata[71:67]);
        end
    endtask

    // Everything is sampled at the rising edge, before the edge's updates land.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_swap = 1'b0;
            cfg_offset = '0;
            cfg_step = MECH_STEP_RESET;
            prev_pat = '0;
            cur_pat = '0;
            fresh = 1'b1;
            angle_hold = '0;
            deg_hold = '0;
            sec_hold = '0;
            mech_hold = '0;
            angle_reports.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SWAP_BC:      cfg_swap = cfg_wdata[0];
                    CFG_ANGLE_OFFSET: cfg_offset = cfg_wdata;
                    CFG_MECH_STEP:    cfg_step = cfg_wdata;
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_capture(s_tdata[2:0]);
            end
            if (m_tvalid && m_tready) begin
                match_report();
            end
        end
        outstanding <= angle_reports.size();
    end

endmodule

// ===== verif/tb_hall_sensor_angle_decoder.sv =====
// ----------------------------------------------------------------------------
// Hall sensor angle decoder testbench
// Drives Hall captures into the decoder through a series of configuration
// settings: a short directed opening, random rotor walks mixed with invalid
// patterns and illegal jumps, a long output stall, and a short full-speed
// spin in both directions at the largest step. A separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_hall_sensor_angle_decoder;
    import hsad_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = CFG_SWAP_BC;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [2:0] hall_bits, [7:3] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;           // [2:0] hall_state, [20:3] elec_angle,
                                    // [29:21] elec_degrees, [32:30] elec_sector,
                                    // [64:33] mech_angle, [66:65] step_dir,
                                    // [71:67] zero
    logic [1:0]  m_tuser;           // [1:0] status

    int fail_count;
    int outstanding;
    int cycles = 0;

    // Stimulus state: rotor sector, current swap setting, sender pacing.
    int   rotor = 0;
    logic swap_now = 1'b0;
    bit   flood = 1'b0;
    logic squeeze = 1'b0;
    int   sender_run = 0;
    bit   sender_steady = 1'b0;

    hall_sensor_angle_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    hall_decode_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("tb_hall_sensor_angle_decoder NOT OK");
                $finish;
            end
        end
    end

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Raw sensor bits that decode to the given sector under the current swap.
    function automatic logic [2:0] hall_code(input int sec);
        logic [2:0] p;
        case (sec)
            0:       p = 3'd4;
            1:       p = 3'd6;
            2:       p = 3'd2;
            3:       p = 3'd3;
            4:       p = 3'd1;
            default: p = 3'd5;
        endcase
        return swap_now ? {p[1], p[2], p[0]} : p;
    endfunction

    // Offer one capture word and hold it until the decoder takes it.
    task automatic send_capture(input logic [2:0] raw);
        int gap;
        if (sender_run == 0) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            sender_run = $urandom_range(20, 120);
        end
        sender_run--;
        gap = 0;
        if (!sender_steady && !flood && $urandom_range(0, 2) == 0) gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, raw};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly legal rotor moves, some invalid patterns and some jumps.
    task automatic send_random();
        int         r;
        logic [2:0] raw;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            r = $urandom_range(0, 9);
            if (r < 4) rotor = (rotor + 1) % 6;
            else if (r < 8) rotor = (rotor + 5) % 6;
            raw = hall_code(rotor);
        end else if (r < 90) begin
            raw = $urandom_range(0, 1) ? 3'd7 : 3'd0;
        end else begin
            rotor = $urandom_range(0, 5);
            raw = hall_code(rotor);
        end
        send_capture(raw);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all three registers on consecutive edges.
    task automatic load_settings(input logic [15:0] swap, input logic [15:0] offs,
                                 input logic [15:0] mstep);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_SWAP_BC;
        cfg_wdata <= swap;
        @(posedge aclk);
        cfg_addr <= CFG_ANGLE_OFFSET;
        cfg_wdata <= offs;
        @(posedge aclk);
        cfg_addr <= CFG_MECH_STEP;
        cfg_wdata <= mstep;
        @(posedge aclk);
        cfg_we <= 1'b0;
        swap_now = swap[0];
    endtask

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial begin : results_sink
        int hold;
        int span;
        bit calm;
        bit squeezed;
        hold = 0;
        span = 0;
        calm = 1'b1;
        squeezed = 1'b0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(40, 250);
            end
            span--;
            if (squeeze && !squeezed) begin
                squeezed = 1'b1;
                hold = 400;
            end else if (hold == 0 && !calm && !flood && $urandom_range(0, 2) == 0) begin
                hold = idle_len();
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Main sequence.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Opening at reset settings: invalid patterns before the first valid
        // one, a repeat, both directions, an illegal jump, a run through all six sectors.
        send_capture(3'd0);
        send_capture(3'd7);
        send_capture(3'd4);
        send_capture(3'd4);
        send_capture(3'd6);
        send_capture(3'd4);
        send_capture(3'd2);
        send_capture(3'd3);
        send_capture(3'd1);
        send_capture(3'd5);
        send_capture(3'd4);
        send_capture(3'd6);
        send_capture(3'd0);
        rotor = 1;
        wait_for_results();

        // Random walks under a series of settings, extremes first.
        for (int ph = 1; ph <= 8; ph++) begin
            case (ph)
                1: load_settings(16'hFFFF, 16'h8000, 16'h0001);
                2: load_settings(16'hFFFE, 16'h7FFF, 16'hFFFF);
                3: load_settings(16'h0001, 16'h0000, 16'h0000);
                8: load_settings(16'h0000, 16'h0000, MECH_STEP_RESET);
                default: load_settings(16'($urandom), 16'($urandom),
                                       16'($urandom_range(1, 61440)));
            endcase
            if (ph == 4) begin
                // Keep offering words while the result side holds off.
                squeeze <= 1'b1;
                flood = 1'b1;
                repeat (40) send_random();
                flood = 1'b0;
                repeat (190) send_random();
            end else begin
                repeat (230) send_random();
            end
            wait_for_results();
        end

        // Short spin at the largest step, forward and then backward.
        load_settings(16'h0000, 16'($urandom), 16'hFFFF);
        flood = 1'b1;
        repeat (24) begin
            rotor = (rotor + 1) % 6;
            send_capture(hall_code(rotor));
        end
        repeat (48) begin
            rotor = (rotor + 5) % 6;
            send_capture(hall_code(rotor));
        end
        flood = 1'b0;
        repeat (20) send_random();
        wait_for_results();
        repeat (10) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb_hall_sensor_angle_decoder OK");
        end else begin
            $display("tb_hall_sensor_angle_decoder NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hsad_pkg.sv
hdl/hsad_cfg_regs.sv
hdl/hsad_decode.sv
hdl/hall_sensor_angle_decoder.sv
verif/hall_decode_checker.sv
verif/tb_hall_sensor_angle_decoder.sv
